FILE: rtl/core/bra_pkg.sv
`timescale 1ns / 1ps
// Shared codes for the banker's resource allocator: item kinds, result
// status codes and configuration register indexes. No dependencies.
package bra_pkg;

  typedef enum logic [2:0] {
    KIND_LOAD_ALLOC = 3'd0,
    KIND_LOAD_CLAIM = 3'd1,
    KIND_LOAD_AVAIL = 3'd2,
    KIND_REQUEST    = 3'd3,
    KIND_RELEASE    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_OVER_NEED = 3'd1,
    ST_OVER_AVAIL = 3'd2,
    ST_UNSAFE    = 3'd3,
    ST_RELEASED  = 3'd4
  } status_t;

  localparam logic CFG_PROCESS_COUNT  = 1'b0;
  localparam logic CFG_RESOURCE_COUNT = 1'b1;

endpackage

FILE: rtl/core/bankers_resource_allocator.sv
`timescale 1ns / 1ps
// Banker's algorithm resource allocator, top level. Uses bra_pkg and bra_tables.
// Loads, releases of an unused process and request elements that are not last
// are handled in the idle state. A release sweeps the resources. A last request
// element sweeps them for the claim check and again for the tentative update,
// then the safety check: up to process_count passes over the processes, each
// unfinished process swept again and each finished one skipped, and a rollback
// sweep if unsafe. The sweeps go through the single read port of the tables,
// one resource per cycle. Results are strobed on out_valid for one cycle and
// cannot be held off.
module bankers_resource_allocator #(
  parameter int MAX_PROCS  = 8,
  parameter int MAX_RES    = 4,
  parameter int COUNT_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [3:0] cfg_wdata,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_kind,
  input  logic [2:0] in_process,
  input  logic [1:0] in_resource,
  input  logic [7:0] in_amount,
  input  logic       in_last,
  output logic       out_valid,
  output logic [2:0] out_status,
  output logic [2:0] out_process_echo
);
  import bra_pkg::*;

  localparam int CW   = COUNT_BITS;
  localparam int PW   = $clog2(MAX_PROCS);
  localparam int RW   = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int NPW  = $clog2(MAX_PROCS + 1);
  localparam int NRW  = $clog2(MAX_RES + 1);
  localparam int AW   = PW + RW;
  localparam int WW   = CW + NPW;
  localparam int CMAX = (1 << CW) - 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_APPLY = 8'b0000_0100,
    S_NEXT  = 8'b0000_1000,
    S_SCAN  = 8'b0001_0000,
    S_ADD   = 8'b0010_0000,
    S_ROLL  = 8'b0100_0000,
    S_REL   = 8'b1000_0000
  } state_t;

  state_t        state_r, state_nxt;
  logic [3:0]    pcount_r, pcount_nxt;
  logic [2:0]    rcount_r, rcount_nxt;
  logic [CW-1:0] avail_r [MAX_RES];
  logic [CW-1:0] avail_nxt [MAX_RES];
  logic [CW-1:0] pend_r [MAX_RES];
  logic [CW-1:0] pend_nxt [MAX_RES];
  logic [WW-1:0] work_r [MAX_RES];
  logic [WW-1:0] work_nxt [MAX_RES];
  logic [CW-1:0] tmp_r [MAX_RES];
  logic [CW-1:0] tmp_nxt [MAX_RES];
  logic          done_r [MAX_PROCS];
  logic          done_nxt [MAX_PROCS];
  logic [PW-1:0] row_r, row_nxt;
  logic [PW-1:0] reqrow_r, reqrow_nxt;
  logic [2:0]    echo_r, echo_nxt;
  logic [NRW-1:0] sw_cnt_r, sw_cnt_nxt;
  logic          sw_dv_r, sw_dv_nxt;
  logic [RW-1:0] sw_dj_r, sw_dj_nxt;
  logic [NPW-1:0] i_r, i_nxt;
  logic [NPW-1:0] fin_r, fin_nxt;
  logic          prog_r, prog_nxt;
  logic          fits_r, fits_nxt;
  logic          overc_r, overc_nxt;
  logic          overa_r, overa_nxt;
  logic          res_v_r, res_v_nxt;
  logic [2:0]    status_r, status_nxt;

  logic [NPW-1:0] np;
  logic [NRW-1:0] nr;
  logic           issue;
  logic           sweep_last;
  logic [CW-1:0]  rd_alloc, rd_claim;
  logic signed [CW:0] need;
  logic           wr_alloc_en, wr_claim_en;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [CW-1:0]  wr_data;
  logic [CW-1:0]  amt_sat;
  logic           p_in_tbl, r_in_tbl;
  logic [CW:0]    sat_sum;
  logic           over_c_now, over_a_now, fits_now;

  bra_tables #(.AW(AW), .CW(CW)) u_tables (
    .clk        (clk),
    .wr_alloc_en(wr_alloc_en),
    .wr_claim_en(wr_claim_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .rd_alloc   (rd_alloc),
    .rd_claim   (rd_claim)
  );

  always_comb begin
    if (pcount_r == 4'd0) begin
      np = NPW'(1);
    end else if (32'(pcount_r) > MAX_PROCS) begin
      np = NPW'(MAX_PROCS);
    end else begin
      np = NPW'(pcount_r);
    end
    if (rcount_r == 3'd0) begin
      nr = NRW'(1);
    end else if (32'(rcount_r) > MAX_RES) begin
      nr = NRW'(MAX_RES);
    end else begin
      nr = NRW'(rcount_r);
    end
  end

  assign amt_sat  = (32'(in_amount) > CMAX) ? CW'(CMAX) : CW'(in_amount);
  assign p_in_tbl = 32'(in_process) < MAX_PROCS;
  assign r_in_tbl = 32'(in_resource) < MAX_RES;

  assign issue      = (state_r != S_IDLE) && (state_r != S_NEXT) && (state_r != S_ADD)
                      && (sw_cnt_r < nr);
  assign sweep_last = sw_dv_r && (sw_dj_r == RW'(nr - NRW'(1)));
  assign rd_addr    = {row_r, sw_cnt_r[RW-1:0]};
  assign need       = $signed({1'b0, rd_claim}) - $signed({1'b0, rd_alloc});
  assign sat_sum    = {1'b0, avail_r[sw_dj_r]} + {1'b0, rd_alloc};

  assign over_c_now = $signed({1'b0, pend_r[sw_dj_r]}) > need;
  assign over_a_now = pend_r[sw_dj_r] > avail_r[sw_dj_r];
  assign fits_now   = !(!need[CW] && (WW'(need[CW-1:0]) > work_r[sw_dj_r]));

  always_comb begin
    state_nxt  = state_r;
    pcount_nxt = pcount_r;
    rcount_nxt = rcount_r;
    avail_nxt  = avail_r;
    pend_nxt   = pend_r;
    work_nxt   = work_r;
    tmp_nxt    = tmp_r;
    done_nxt   = done_r;
    row_nxt    = row_r;
    reqrow_nxt = reqrow_r;
    echo_nxt   = echo_r;
    i_nxt      = i_r;
    fin_nxt    = fin_r;
    prog_nxt   = prog_r;
    fits_nxt   = fits_r;
    overc_nxt  = overc_r;
    overa_nxt  = overa_r;
    res_v_nxt  = 1'b0;
    status_nxt = status_r;
    sw_cnt_nxt = issue ? sw_cnt_r + NRW'(1) : sw_cnt_r;
    sw_dv_nxt  = issue;
    sw_dj_nxt  = sw_cnt_r[RW-1:0];
    wr_alloc_en = 1'b0;
    wr_claim_en = 1'b0;
    wr_addr     = {row_r, sw_dj_r};
    wr_data     = rd_alloc;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROCESS_COUNT:  pcount_nxt = cfg_wdata;
        CFG_RESOURCE_COUNT: rcount_nxt = cfg_wdata[2:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        wr_addr = {PW'(in_process), RW'(in_resource)};
        wr_data = amt_sat;
        sw_cnt_nxt = '0;
        sw_dv_nxt  = 1'b0;
        if (start) begin
          echo_nxt   = in_process;
          row_nxt    = PW'(in_process);
          reqrow_nxt = PW'(in_process);
          case (in_kind)
            KIND_LOAD_ALLOC: wr_alloc_en = p_in_tbl && r_in_tbl;
            KIND_LOAD_CLAIM: wr_claim_en = p_in_tbl && r_in_tbl;
            KIND_LOAD_AVAIL: begin
              if (r_in_tbl) begin
                avail_nxt[RW'(in_resource)] = amt_sat;
              end
            end
            KIND_REQUEST: begin
              if (r_in_tbl) begin
                pend_nxt[RW'(in_resource)] = amt_sat;
              end
              if (in_last) begin
                if (NPW'(in_process) >= np || !p_in_tbl) begin
                  res_v_nxt  = 1'b1;
                  status_nxt = ST_OVER_NEED;
                  for (int j = 0; j < MAX_RES; j++) pend_nxt[j] = '0;
                end else begin
                  overc_nxt = 1'b0;
                  overa_nxt = 1'b0;
                  state_nxt = S_CHECK;
                end
              end
            end
            KIND_RELEASE: begin
              if (NPW'(in_process) >= np || !p_in_tbl) begin
                res_v_nxt  = 1'b1;
                status_nxt = ST_RELEASED;
              end else begin
                state_nxt = S_REL;
              end
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (sw_dv_r) begin
          overc_nxt = overc_r | over_c_now;
          overa_nxt = overa_r | over_a_now;
          if (sweep_last) begin
            sw_cnt_nxt = '0;
            sw_dv_nxt  = 1'b0;
            if (overc_nxt) begin
              res_v_nxt  = 1'b1;
              status_nxt = ST_OVER_NEED;
              state_nxt  = S_IDLE;
              for (int j = 0; j < MAX_RES; j++) pend_nxt[j] = '0;
            end else if (overa_nxt) begin
              res_v_nxt  = 1'b1;
              status_nxt = ST_OVER_AVAIL;
              state_nxt  = S_IDLE;
              for (int j = 0; j < MAX_RES; j++) pend_nxt[j] = '0;
            end else begin
              state_nxt = S_APPLY;
            end
          end
        end
      end
      S_APPLY: begin
        if (sw_dv_r) begin
          wr_alloc_en = 1'b1;
          wr_data     = rd_alloc + pend_r[sw_dj_r];
          avail_nxt[sw_dj_r] = avail_r[sw_dj_r] - pend_r[sw_dj_r];
          if (sweep_last) begin
            for (int j = 0; j < MAX_RES; j++) work_nxt[j] = WW'(avail_nxt[j]);
            for (int k = 0; k < MAX_PROCS; k++) done_nxt[k] = 1'b0;
            i_nxt     = '0;
            fin_nxt   = '0;
            prog_nxt  = 1'b0;
            state_nxt = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        sw_cnt_nxt = '0;
        sw_dv_nxt  = 1'b0;
        if (i_r == np) begin
          if (fin_r == np) begin
            res_v_nxt  = 1'b1;
            status_nxt = ST_GRANTED;
            state_nxt  = S_IDLE;
            for (int j = 0; j < MAX_RES; j++) pend_nxt[j] = '0;
          end else if (!prog_r) begin
            row_nxt   = reqrow_r;
            state_nxt = S_ROLL;
          end else begin
            i_nxt    = '0;
            prog_nxt = 1'b0;
          end
        end else if (done_r[PW'(i_r)]) begin
          i_nxt = i_r + NPW'(1);
        end else begin
          row_nxt   = PW'(i_r);
          fits_nxt  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sw_dv_r) begin
          fits_nxt = fits_r & fits_now;
          tmp_nxt[sw_dj_r] = rd_alloc;
          if (sweep_last) begin
            state_nxt = S_ADD;
          end
        end
      end
      S_ADD: begin
        if (fits_r) begin
          for (int j = 0; j < MAX_RES; j++) begin
            if (NRW'(j) < nr) begin
              work_nxt[j] = work_r[j] + WW'(tmp_r[j]);
            end
          end
          done_nxt[PW'(i_r)] = 1'b1;
          fin_nxt  = fin_r + NPW'(1);
          prog_nxt = 1'b1;
        end
        i_nxt     = i_r + NPW'(1);
        state_nxt = S_NEXT;
      end
      S_ROLL: begin
        if (sw_dv_r) begin
          wr_alloc_en = 1'b1;
          wr_data     = rd_alloc - pend_r[sw_dj_r];
          avail_nxt[sw_dj_r] = avail_r[sw_dj_r] + pend_r[sw_dj_r];
          if (sweep_last) begin
            res_v_nxt  = 1'b1;
            status_nxt = ST_UNSAFE;
            state_nxt  = S_IDLE;
            for (int j = 0; j < MAX_RES; j++) pend_nxt[j] = '0;
          end
        end
      end
      S_REL: begin
        if (sw_dv_r) begin
          wr_alloc_en = 1'b1;
          wr_data     = '0;
          avail_nxt[sw_dj_r] = sat_sum[CW] ? CW'(CMAX) : sat_sum[CW-1:0];
          if (sweep_last) begin
            res_v_nxt  = 1'b1;
            status_nxt = ST_RELEASED;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pcount_r <= 4'd8;
      rcount_r <= 3'd4;
      res_v_r  <= 1'b0;
      sw_cnt_r <= '0;
      sw_dv_r  <= 1'b0;
      for (int j = 0; j < MAX_RES; j++) pend_r[j] <= '0;
      for (int k = 0; k < MAX_PROCS; k++) done_r[k] <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pcount_r <= pcount_nxt;
      rcount_r <= rcount_nxt;
      res_v_r  <= res_v_nxt;
      sw_cnt_r <= sw_cnt_nxt;
      sw_dv_r  <= sw_dv_nxt;
      pend_r   <= pend_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    avail_r  <= avail_nxt;
    work_r   <= work_nxt;
    tmp_r    <= tmp_nxt;
    row_r    <= row_nxt;
    reqrow_r <= reqrow_nxt;
    echo_r   <= echo_nxt;
    sw_dj_r  <= sw_dj_nxt;
    i_r      <= i_nxt;
    fin_r    <= fin_nxt;
    prog_r   <= prog_nxt;
    fits_r   <= fits_nxt;
    overc_r  <= overc_nxt;
    overa_r  <= overa_nxt;
    status_r <= status_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = res_v_r;
  assign out_status       = status_r;
  assign out_process_echo = echo_r;

endmodule

FILE: rtl/core/bra_tables.sv
`timescale 1ns / 1ps
// Allocation and claim tables of the allocator, one synchronous memory each,
// with a shared address for reading and one for writing. Uses bra_pkg.
module bra_tables #(
  parameter int AW = 5,
  parameter int CW = 8
) (
  input  logic          clk,
  input  logic          wr_alloc_en,
  input  logic          wr_claim_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [CW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [CW-1:0] rd_alloc,
  output logic [CW-1:0] rd_claim
);
  import bra_pkg::*;

  logic [CW-1:0] alloc_mem [1<<AW];
  logic [CW-1:0] claim_mem [1<<AW];

  always_ff @(posedge clk) begin
    if (wr_alloc_en) begin
      alloc_mem[wr_addr] <= wr_data;
    end
    rd_alloc <= alloc_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_claim_en) begin
      claim_mem[wr_addr] <= wr_data;
    end
    rd_claim <= claim_mem[rd_addr];
  end

endmodule
